>>> sv/stlp_pkg.sv
// Shared types, codes and helpers for the sensor telemetry line parser.
// No dependencies; used by every module of the block.
package stlp_pkg;

	localparam int ENCODER_COUNT_DEF = 4;
	localparam int IR_COUNT_DEF      = 8;
	localparam int IMU_COUNT_DEF     = 8;

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_ONE   = 8'd49;
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_A     = 8'd65;
	localparam logic [7:0] CH_E     = 8'd69;
	localparam logic [7:0] CH_I     = 8'd73;
	localparam logic [7:0] CH_RBR   = 8'd93;

	localparam logic [31:0] MAG_CAP = 32'h8000_0000;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		KIND_ENC = 2'd0,
		KIND_IR  = 2'd1,
		KIND_IMU = 2'd2,
		KIND_ERR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		LK_NONE = 2'd0,
		LK_ENC  = 2'd1,
		LK_IR   = 2'd2,
		LK_IMU  = 2'd3
	} line_kind_t;

	typedef enum logic [1:0] {
		NP_SKIP   = 2'd0,
		NP_SIGN   = 2'd1,
		NP_DIGITS = 2'd2,
		NP_DONE   = 2'd3
	} num_phase_t;

	typedef struct packed {
		num_phase_t  phase;
		logic        neg;
		logic [31:0] acc;
	} num_t;

	typedef struct packed {
		logic        stopped;
		logic [1:0]  pos;
		line_kind_t  kind;
		logic        bracket_only;
		logic [7:0]  index_char;
		num_t        num;
		logic [6:0]  imu_slot;
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [5:0]         slot;
		logic signed [31:0] value;
		logic               run_last;
	} result_t;

	// up to two results per byte, r0 first
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} res_bundle_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// one byte of atoi-style number scanning; magnitude saturates at 2^31
	function automatic num_t feed_digit(input num_t n, input logic [7:0] c);
		num_t        r;
		logic        done;
		logic [35:0] t;
		r    = n;
		done = 1'b0;
		t    = '0;
		if (r.phase == NP_SKIP) begin
			if (is_space(c)) begin
				done = 1'b1;
			end else if (c == CH_PLUS) begin
				r.phase = NP_SIGN;
				done    = 1'b1;
			end else if (c == CH_MINUS) begin
				r.neg   = 1'b1;
				r.phase = NP_SIGN;
				done    = 1'b1;
			end
		end
		if (!done && r.phase != NP_DONE) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				t = ({4'b0, r.acc} << 3) + ({4'b0, r.acc} << 1) + {28'b0, c - CH_ZERO};
				r.acc   = (t > {4'b0, MAG_CAP}) ? MAG_CAP : t[31:0];
				r.phase = NP_DIGITS;
			end else begin
				r.phase = NP_DONE;
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] number_value(input num_t n);
		if (n.neg)
			return 32'd0 - n.acc;
		return n.acc[31] ? POS_MAX : n.acc;
	endfunction

endpackage

>>> sv/sensor_telemetry_line_parser.sv
// Telemetry line parser: one byte per cycle in, sensor writes and errors out.
// With the queue empty, a result is offered on m_tvalid once its byte has passed
// the input register and then the result queue write.
// Throughput: 1 byte per cycle while results drain at one per cycle; a byte
// that yields two results needs two transfers on the single result port.
// Reset (arst_n low): parser state clears, input register and queue empty.
// Depends on stlp_pkg, stlp_core, stlp_fifo.
module sensor_telemetry_line_parser #(
	parameter int ENCODER_COUNT = stlp_pkg::ENCODER_COUNT_DEF,
	parameter int IR_COUNT      = stlp_pkg::IR_COUNT_DEF,
	parameter int IMU_COUNT     = stlp_pkg::IMU_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tlast,   // msg_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [5:0] slot, [37:6] value, [39:38] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // run_last
);

	logic                  valid_s1;
	logic [7:0]            ch_s1;
	logic                  last_s1;
	logic                  room;
	logic                  fire;
	stlp_pkg::res_bundle_t res;
	stlp_pkg::result_t     head;

	assign fire     = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	stlp_core #(
		.ENCODER_COUNT(ENCODER_COUNT),
		.IR_COUNT     (IR_COUNT),
		.IMU_COUNT    (IMU_COUNT)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.ch      (ch_s1),
		.msg_last(last_s1),
		.res     (res)
	);

	stlp_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res),
		.pop   (m_tready),
		.room  (room),
		.valid (m_tvalid),
		.head  (head)
	);

	assign m_tdata = {2'b00, head.value, head.slot};
	assign m_tuser = head.kind;
	assign m_tlast = head.run_last;

endmodule

>>> sv/stlp_core.sv
// Parser state and per-byte decode: one byte in, up to two results out.
// Depends on stlp_pkg.
module stlp_core #(
	parameter int ENCODER_COUNT = stlp_pkg::ENCODER_COUNT_DEF,
	parameter int IR_COUNT      = stlp_pkg::IR_COUNT_DEF,
	parameter int IMU_COUNT     = stlp_pkg::IMU_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  logic [7:0]             ch,
	input  logic                   msg_last,
	output stlp_pkg::res_bundle_t  res
);

	stlp_pkg::state_t state_q;
	stlp_pkg::state_t state_d;

	always_comb begin : parse
		stlp_pkg::state_t  st;
		stlp_pkg::result_t e;
		logic              have_e;
		logic [1:0]        pos;
		logic [7:0]        idx;
		logic [6:0]        cnt;
		st     = state_q;
		e      = '0;
		have_e = 1'b0;
		pos    = st.pos;
		idx    = st.index_char - stlp_pkg::CH_ONE;
		cnt    = '0;
		res    = '0;

		if (fire && !st.stopped && ch != stlp_pkg::CH_LF) begin
			if (pos == 2'd0) begin
				st.kind = (ch == stlp_pkg::CH_E) ? stlp_pkg::LK_ENC :
				          (ch == stlp_pkg::CH_I) ? stlp_pkg::LK_IR  :
				          (ch == stlp_pkg::CH_A) ? stlp_pkg::LK_IMU : stlp_pkg::LK_NONE;
				st.bracket_only = (ch == stlp_pkg::CH_RBR);
			end else begin
				st.bracket_only = 1'b0;
			end
			if (pos == 2'd1)
				st.index_char = ch;
			if (st.kind == stlp_pkg::LK_IMU && pos >= 2'd2) begin
				if (ch == stlp_pkg::CH_COLON) begin
					res.n = 2'd1;
					if (st.imu_slot >= 7'(IMU_COUNT)) begin
						res.r0.kind = stlp_pkg::KIND_ERR;
						st.stopped  = 1'b1;
					end else begin
						res.r0.kind  = stlp_pkg::KIND_IMU;
						res.r0.slot  = st.imu_slot[5:0];
						res.r0.value = stlp_pkg::number_value(st.num);
						st.imu_slot  = st.imu_slot + 7'd1;
						st.num       = '0;
					end
				end else begin
					st.num = stlp_pkg::feed_digit(st.num, ch);
				end
			end else if ((st.kind == stlp_pkg::LK_ENC || st.kind == stlp_pkg::LK_IR)
			             && pos == 2'd3) begin
				st.num = stlp_pkg::feed_digit(st.num, ch);
			end
			st.pos = (pos == 2'd3) ? 2'd3 : pos + 2'd1;
		end

		// end of line: newline, or last byte of the message
		if (fire && !st.stopped && (ch == stlp_pkg::CH_LF || msg_last)) begin
			idx = st.index_char - stlp_pkg::CH_ONE;
			cnt = (st.kind == stlp_pkg::LK_ENC) ? 7'(ENCODER_COUNT) : 7'(IR_COUNT);
			if (st.pos == 2'd1 && st.bracket_only) begin
				st.stopped = 1'b1;
			end else if (st.kind == stlp_pkg::LK_ENC || st.kind == stlp_pkg::LK_IR) begin
				have_e = 1'b1;
				if (st.pos != 2'd3 || st.index_char < stlp_pkg::CH_ONE
				    || idx >= {1'b0, cnt}) begin
					e.kind     = stlp_pkg::KIND_ERR;
					st.stopped = 1'b1;
				end else begin
					e.kind  = (st.kind == stlp_pkg::LK_ENC) ? stlp_pkg::KIND_ENC
					                                        : stlp_pkg::KIND_IR;
					e.slot  = idx[5:0];
					e.value = stlp_pkg::number_value(st.num);
				end
			end else if (st.kind == stlp_pkg::LK_IMU) begin
				have_e = 1'b1;
				if (st.pos < 2'd2 || st.imu_slot >= 7'(IMU_COUNT)) begin
					e.kind     = stlp_pkg::KIND_ERR;
					st.stopped = 1'b1;
				end else begin
					e.kind  = stlp_pkg::KIND_IMU;
					e.slot  = st.imu_slot[5:0];
					e.value = stlp_pkg::number_value(st.num);
				end
			end
			st.pos          = '0;
			st.kind         = stlp_pkg::LK_NONE;
			st.bracket_only = 1'b0;
			st.index_char   = '0;
			st.imu_slot     = '0;
			st.num          = '0;
		end

		if (have_e) begin
			if (res.n == 2'd0)
				res.r0 = e;
			else
				res.r1 = e;
			res.n = res.n + 2'd1;
		end

		if (res.n == 2'd2)
			res.r1.run_last = 1'b1;
		else if (res.n == 2'd1)
			res.r0.run_last = 1'b1;

		if (fire && msg_last)
			st = '0;

		state_d = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/stlp_fifo.sv
// Four-entry result queue; takes zero, one or two results per cycle, gives one.
// Depends on stlp_pkg.
module stlp_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stlp_pkg::res_bundle_t push,
	input  logic                  pop,
	output logic                  room,
	output logic                  valid,
	output stlp_pkg::result_t     head
);

	stlp_pkg::result_t mem_q [4];
	logic [1:0]        wr_ptr_q;
	logic [1:0]        rd_ptr_q;
	logic [2:0]        count_q;
	logic              do_pop;

	assign valid  = (count_q != 3'd0);
	assign head   = mem_q[rd_ptr_q];
	// two free entries, judged before this cycle's pop
	assign room   = (count_q <= 3'd2);
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wr_ptr_q] <= push.r0;
		if (push.n == 2'd2)
			mem_q[wr_ptr_q + 2'd1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.n;
			rd_ptr_q <= rd_ptr_q + {1'b0, do_pop};
			count_q  <= count_q + {1'b0, push.n} - {2'b0, do_pop};
		end
	end

endmodule

>>> sv/stlp_checker.sv
// Port-level checks for the telemetry line parser, bound to the top level.
// Depends on stlp_pkg and sensor_telemetry_line_parser.
module stlp_checker #(
	parameter int ENCODER_COUNT = stlp_pkg::ENCODER_COUNT_DEF,
	parameter int IR_COUNT      = stlp_pkg::IR_COUNT_DEF,
	parameter int IMU_COUNT     = stlp_pkg::IMU_COUNT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// stalled request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("stalled result changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == stlp_pkg::KIND_ERR |-> m_tdata == 40'd0 && m_tlast)
		else $error("error result carries data");

	a_enc_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == stlp_pkg::KIND_ENC |-> m_tdata[5:0] < ENCODER_COUNT)
		else $error("encoder slot out of range");

	a_ir_imu_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == stlp_pkg::KIND_IR || m_tuser == stlp_pkg::KIND_IMU)
		|-> m_tdata[5:0] < ((m_tuser == stlp_pkg::KIND_IR) ? IR_COUNT : IMU_COUNT))
		else $error("ir or imu slot out of range");

endmodule

bind sensor_telemetry_line_parser stlp_checker #(
	.ENCODER_COUNT(ENCODER_COUNT),
	.IR_COUNT     (IR_COUNT),
	.IMU_COUNT    (IMU_COUNT)
) u_stlp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
